### hw/rtl/rne_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_pkg: shared types and letter tables for the Roman numeral encoder
// Digit record passed from the front end to the back end, ASCII letters,
// and the per-digit length and letter lookup.
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int VALUE_W     = 14;
    localparam int LETTER_W    = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int VALUE_MAX   = 9999;

    // ASCII codes
    localparam logic [LETTER_W-1:0] CH_M    = 7'h4D;
    localparam logic [LETTER_W-1:0] CH_D    = 7'h44;
    localparam logic [LETTER_W-1:0] CH_C    = 7'h43;
    localparam logic [LETTER_W-1:0] CH_L    = 7'h4C;
    localparam logic [LETTER_W-1:0] CH_X    = 7'h58;
    localparam logic [LETTER_W-1:0] CH_V    = 7'h56;
    localparam logic [LETTER_W-1:0] CH_I    = 7'h49;
    localparam logic [LETTER_W-1:0] CH_DASH = 7'h2D;
    localparam logic [LETTER_W-1:0] CH_NONE = 7'h00;

    // decimal positions, most significant first
    localparam logic [1:0] POS_THOU = 2'd0;
    localparam logic [1:0] POS_HUND = 2'd1;
    localparam logic [1:0] POS_TENS = 2'd2;
    localparam logic [1:0] POS_UNIT = 2'd3;

    typedef enum logic [1:0] {
        SYM_ONE  = 2'd0,
        SYM_FIVE = 2'd1,
        SYM_TEN  = 2'd2
    } sym_t;

    typedef struct packed {
        logic       err;
        logic [3:0] thou;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] unit;
    } digits_t;

    // number of letters a digit produces at a given position
    function automatic logic [2:0] digit_len(input logic [1:0] pos, input logic [3:0] dig);
        logic [2:0] len;
        begin
            case (dig) inside
                4'd1, 4'd5:        len = 3'd1;
                4'd2, 4'd6:        len = 3'd2;
                4'd3, 4'd7:        len = 3'd3;
                4'd4, 4'd9:        len = 3'd2;
                4'd8:              len = 3'd4;
                default:           len = 3'd0;
            endcase
            // overline forms add one dash
            if (pos == POS_THOU && dig >= 4'd4 && dig <= 4'd9) begin
                len = len + 3'd1;
            end
            digit_len = len;
        end
    endfunction

    // one-five-ten pattern for positions below thousands
    function automatic sym_t digit_sym(input logic [3:0] dig, input logic [2:0] idx);
        sym_t s;
        begin
            case (dig) inside
                4'd4:             s = (idx == 3'd0) ? SYM_ONE : SYM_FIVE;
                4'd5:             s = SYM_FIVE;
                4'd6, 4'd7, 4'd8: s = (idx == 3'd0) ? SYM_FIVE : SYM_ONE;
                4'd9:             s = (idx == 3'd0) ? SYM_ONE : SYM_TEN;
                default:          s = SYM_ONE;
            endcase
            digit_sym = s;
        end
    endfunction

    function automatic logic [LETTER_W-1:0] thou_char(input logic [3:0] dig,
                                                      input logic [2:0] idx);
        logic [LETTER_W-1:0] c;
        begin
            case (dig) inside
                4'd4: begin
                    c = (idx == 3'd0) ? CH_M : ((idx == 3'd1) ? CH_V : CH_DASH);
                end
                4'd5: begin
                    c = (idx == 3'd0) ? CH_V : CH_DASH;
                end
                4'd6, 4'd7, 4'd8: begin
                    c = (idx == 3'd0) ? CH_V : ((idx == 3'd1) ? CH_DASH : CH_M);
                end
                4'd9: begin
                    c = (idx == 3'd0) ? CH_M : ((idx == 3'd1) ? CH_X : CH_DASH);
                end
                default: begin
                    c = CH_M;
                end
            endcase
            thou_char = c;
        end
    endfunction

    function automatic logic [LETTER_W-1:0] roman_char(input logic [1:0] pos,
                                                       input logic [3:0] dig,
                                                       input logic [2:0] idx);
        logic [LETTER_W-1:0] c;
        sym_t                s;
        begin
            s = digit_sym(dig, idx);
            unique case (pos)
                POS_THOU: c = thou_char(dig, idx);
                POS_HUND: c = (s == SYM_ONE) ? CH_C : ((s == SYM_FIVE) ? CH_D : CH_M);
                POS_TENS: c = (s == SYM_ONE) ? CH_X : ((s == SYM_FIVE) ? CH_L : CH_C);
                POS_UNIT: c = (s == SYM_ONE) ? CH_I : ((s == SYM_FIVE) ? CH_V : CH_X);
                default:  c = CH_NONE;
            endcase
            roman_char = c;
        end
    endfunction

endpackage

### hw/rtl/roman_numeral_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder: binary number to Roman numeral letter stream
// Converts a 14-bit number (1..9999) into ASCII Roman letters, most
// significant digit first, with overline forms for thousands four and up.
// ----------------------------------------------------------------------------
//
//  channel   ports                               dir   one request is
//  -------   ---------------------------------   ---   ------------------------
//  input     s_valid s_ready s_value[13:0]       in    one number to convert
//  result    m_valid m_ready m_letter[6:0]       out   one letter, or an error
//            m_last m_error                            marker for 0 / >9999
//
//  Output rate: one letter per cycle from the back-end output register unless
//  the result is stalled; a number yields 1 to 17 letters (17 for 8888).
//  Input side takes one request per cycle while the digit pipeline and the
//  queue have room; a number passes through both, then the back-end registers.
//  Synchronous active-low reset clears all valid flags; no clearing pass.
//  Either side may stall independently; a stalled result holds its letter.
//
module roman_numeral_encoder #(
    parameter int QueueDepth = rne_pkg::QUEUE_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [rne_pkg::VALUE_W-1:0]  s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rne_pkg::LETTER_W-1:0] m_letter,
    output logic                         m_last,
    output logic                         m_error
);

    // digit records between the splitter and the letter sequencer
    logic             push_valid, push_ready;
    rne_pkg::digits_t push_data;
    logic             pop_valid, pop_ready;
    rne_pkg::digits_t pop_data;

    // front end: range check plus three divide-by-ten stages
    rne_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // queue lets the splitter run ahead while long numerals drain
    rne_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back end: letter sequencing, pops the next record on the last letter
    rne_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_letter  (m_letter),
        .m_last    (m_last),
        .m_error   (m_error)
    );

endmodule

### hw/rtl/rne_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_front: request intake and decimal split
// Three-stage pipeline; each stage peels one decimal digit with a
// reciprocal multiply. Range check is done on intake.
// ----------------------------------------------------------------------------
module rne_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rne_pkg::VALUE_W-1:0] s_value,
    output logic                        push_valid,
    input  logic                        push_ready,
    output rne_pkg::digits_t            push_data
);

    // floor(x/10), exact for any 14-bit x
    function automatic logic [10:0] div10(input logic [13:0] x);
        logic [29:0] p;
        begin
            p     = 30'(x) * 30'd52429;
            div10 = p[29:19];
        end
    endfunction

    function automatic logic [3:0] rem10(input logic [13:0] x, input logic [10:0] q);
        logic [13:0] q10;
        begin
            q10   = (14'(q) << 3) + (14'(q) << 1);
            rem10 = 4'(x - q10);
        end
    endfunction

    logic        v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic        rdy1, rdy2, rdy3;
    logic [10:0] q1_reg, q1_next;
    logic [7:0]  q2_reg, q2_next;
    logic [3:0]  un1_reg, un1_next, un2_reg, un2_next;
    logic        err1_reg, err1_next, err2_reg, err2_next;
    logic [3:0]  te2_reg, te2_next;
    rne_pkg::digits_t d3_reg, d3_next;
    logic [10:0] q2_full, q3_full;

    assign rdy3    = !v3_reg || push_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    assign push_valid = v3_reg;
    assign push_data  = d3_reg;

    always_comb begin
        v1_next   = v1_reg;
        v2_next   = v2_reg;
        v3_next   = v3_reg;
        q1_next   = q1_reg;
        un1_next  = un1_reg;
        err1_next = err1_reg;
        q2_next   = q2_reg;
        te2_next  = te2_reg;
        un2_next  = un2_reg;
        err2_next = err2_reg;
        d3_next   = d3_reg;
        q2_full   = div10(14'(q1_reg));
        q3_full   = div10(14'(q2_reg));
        if (rdy1) begin
            v1_next   = s_valid;
            q1_next   = div10(s_value);
            un1_next  = rem10(s_value, div10(s_value));
            err1_next = (s_value == '0) || (32'(s_value) > rne_pkg::VALUE_MAX);
        end
        if (rdy2) begin
            v2_next   = v1_reg;
            q2_next   = q2_full[7:0];
            te2_next  = rem10(14'(q1_reg), q2_full);
            un2_next  = un1_reg;
            err2_next = err1_reg;
        end
        if (rdy3) begin
            v3_next      = v2_reg;
            d3_next.err  = err2_reg;
            d3_next.thou = q3_full[3:0];
            d3_next.hund = rem10(14'(q2_reg), q3_full);
            d3_next.tens = te2_reg;
            d3_next.unit = un2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
        q1_reg   <= q1_next;
        un1_reg  <= un1_next;
        err1_reg <= err1_next;
        q2_reg   <= q2_next;
        te2_reg  <= te2_next;
        un2_reg  <= un2_next;
        err2_reg <= err2_next;
        d3_reg   <= d3_next;
    end

endmodule

### hw/rtl/rne_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_queue: small digit-record FIFO
// Decouples the digit split from letter emission.
// ----------------------------------------------------------------------------
module rne_queue #(
    parameter int Depth = rne_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  rne_pkg::digits_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output rne_pkg::digits_t pop_data
);

    localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    rne_pkg::digits_t mem_reg [Depth];
    logic [IdxW-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CntW'(Depth));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == IdxW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == IdxW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hw/rtl/rne_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_back: letter sequencer
// Walks the nonzero digits of one record, or sends one error marker, and
// emits one letter per cycle while not stalled, via a registered output stage.
// ----------------------------------------------------------------------------
module rne_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  rne_pkg::digits_t             pop_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [rne_pkg::LETTER_W-1:0] m_letter,
    output logic                         m_last,
    output logic                         m_error
);

    logic                         busy_reg, busy_next;
    logic                         err_reg, err_next;
    logic [3:0]                   dig_reg [4];
    logic [3:0]                   dig_next [4];
    logic [1:0]                   pos_reg, pos_next;
    logic [2:0]                   ci_reg, ci_next;
    logic                         ovalid_reg, ovalid_next;
    logic [rne_pkg::LETTER_W-1:0] letter_reg, letter_next;
    logic                         last_reg, last_next;
    logic                         error_reg, error_next;

    logic [3:0]                   cur_dig;
    logic [2:0]                   cur_len;
    logic                         dig_end, more, last_c, load_out, emit, take;
    logic [1:0]                   nxt_pos, first_pos;

    assign cur_dig  = dig_reg[pos_reg];
    assign cur_len  = rne_pkg::digit_len(pos_reg, cur_dig);
    assign dig_end  = (ci_reg == cur_len - 3'd1);
    assign last_c   = err_reg || (dig_end && !more);
    assign load_out = !ovalid_reg || m_ready;
    assign emit     = busy_reg && load_out;
    assign pop_ready = !busy_reg || (emit && last_c);
    assign take     = pop_valid && pop_ready;

    // next nonzero digit after the current one
    always_comb begin
        more    = 1'b0;
        nxt_pos = pos_reg;
        for (int i = 3; i >= 0; i--) begin
            if (2'(i) > pos_reg && dig_reg[i] != 4'd0) begin
                more    = 1'b1;
                nxt_pos = 2'(i);
            end
        end
    end

    // leading nonzero digit of the incoming record
    always_comb begin
        first_pos = rne_pkg::POS_UNIT;
        if (pop_data.tens != 4'd0) first_pos = rne_pkg::POS_TENS;
        if (pop_data.hund != 4'd0) first_pos = rne_pkg::POS_HUND;
        if (pop_data.thou != 4'd0) first_pos = rne_pkg::POS_THOU;
    end

    always_comb begin
        busy_next   = busy_reg;
        err_next    = err_reg;
        dig_next    = dig_reg;
        pos_next    = pos_reg;
        ci_next     = ci_reg;
        ovalid_next = ovalid_reg;
        letter_next = letter_reg;
        last_next   = last_reg;
        error_next  = error_reg;

        if (load_out) begin
            ovalid_next = emit;
            letter_next = err_reg ? rne_pkg::CH_NONE
                                  : rne_pkg::roman_char(pos_reg, cur_dig, ci_reg);
            last_next   = last_c;
            error_next  = err_reg;
        end

        if (take) begin
            busy_next                    = 1'b1;
            err_next                     = pop_data.err;
            dig_next[rne_pkg::POS_THOU]  = pop_data.thou;
            dig_next[rne_pkg::POS_HUND]  = pop_data.hund;
            dig_next[rne_pkg::POS_TENS]  = pop_data.tens;
            dig_next[rne_pkg::POS_UNIT]  = pop_data.unit;
            pos_next                     = first_pos;
            ci_next                      = 3'd0;
        end else if (emit) begin
            if (last_c) begin
                busy_next = 1'b0;
            end else if (dig_end) begin
                pos_next = nxt_pos;
                ci_next  = 3'd0;
            end else begin
                ci_next = ci_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
        err_reg    <= err_next;
        dig_reg    <= dig_next;
        pos_reg    <= pos_next;
        ci_reg     <= ci_next;
        letter_reg <= letter_next;
        last_reg   <= last_next;
        error_reg  <= error_next;
    end

    assign m_valid  = ovalid_reg;
    assign m_letter = letter_reg;
    assign m_last   = last_reg;
    assign m_error  = error_reg;

endmodule

### hw/rtl/rne_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rne_checker: port-level checks for the Roman numeral encoder
// Watches the result channel for legal letters and error framing.
// ----------------------------------------------------------------------------
module rne_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [rne_pkg::LETTER_W-1:0] m_letter,
    input logic                         m_last,
    input logic                         m_error
);

    // a stalled result keeps its content
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_letter) && $stable(m_last)
                                 && $stable(m_error))
        else $error("result changed while stalled");

    // an error result is a single marker with no letter
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_last && m_letter == rne_pkg::CH_NONE)
        else $error("malformed error result");

    // normal results carry only numeral letters
    a_letter: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_error |->
            m_letter == rne_pkg::CH_M || m_letter == rne_pkg::CH_D ||
            m_letter == rne_pkg::CH_C || m_letter == rne_pkg::CH_L ||
            m_letter == rne_pkg::CH_X || m_letter == rne_pkg::CH_V ||
            m_letter == rne_pkg::CH_I || m_letter == rne_pkg::CH_DASH)
        else $error("illegal letter");

    // a dash only ever shows up inside a normal numeral
    a_dash: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_letter == rne_pkg::CH_DASH |-> !m_error)
        else $error("dash on error result");

    // nothing comes out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_letter (m_letter),
    .m_last   (m_last),
    .m_error  (m_error)
);
